// File: hdl/tea_pkg.sv
package tea_pkg;

  // Word width of every operand in the cipher.
  localparam int unsigned WordW = 32;

  // Golden-ratio constant added to the running sum once per round.
  localparam logic [WordW-1:0] TeaDelta = 32'h9e37_79b9;

  // Standard round count of the cipher.
  localparam int unsigned DefRoundCount = 32;

  // Key register file: four words, one index each.
  localparam int unsigned KeyCount = 4;
  localparam int unsigned KeyIdxW  = 2;

  localparam logic [KeyIdxW-1:0] KeyIdx0 = 2'd0;
  localparam logic [KeyIdxW-1:0] KeyIdx1 = 2'd1;
  localparam logic [KeyIdxW-1:0] KeyIdx2 = 2'd2;
  localparam logic [KeyIdxW-1:0] KeyIdx3 = 2'd3;

  // Key words after reset.
  localparam logic [WordW-1:0] KeyRst0 = 32'h0123_4567;
  localparam logic [WordW-1:0] KeyRst1 = 32'h89ab_cdef;
  localparam logic [WordW-1:0] KeyRst2 = 32'hfedc_ba98;
  localparam logic [WordW-1:0] KeyRst3 = 32'h7654_3210;

  // Mixing function of one half-round. All adds wrap at the word width.
  function automatic logic [WordW-1:0] tea_mix(
    input logic [WordW-1:0] x,
    input logic [WordW-1:0] sum,
    input logic [WordW-1:0] ka,
    input logic [WordW-1:0] kb
  );
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    a = (x << 4) + ka;
    b = x + sum;
    c = (x >> 5) + kb;
    return a ^ b ^ c;
  endfunction

endpackage

// File: hdl/tea_block_encrypt_top.sv
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+----------------------------------
// block in | plain_left_i, plain_right_i             | beat taken when start_i && !busy_o
// block out| cipher_left_o, cipher_right_o           | one-cycle beat marked by done_o
// key cfg  | cfg_we_i, cfg_idx_i, cfg_wdata_i        | write taken when cfg_we_i is high
//
// Each round is split into two half-round stages, so the pipeline is 2*ROUND_COUNT
// registers deep; an accepted block passes through each of them in order before it shows
// on the outputs. One block enters every cycle; busy_o stays low.
// Reset clears the stage valid bits and loads the default key.
// The output side cannot stall, so the pipeline never holds.
module tea_block_encrypt_top
  import tea_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = DefRoundCount
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [WordW-1:0]   plain_left_i,
  input  logic [WordW-1:0]   plain_right_i,
  output logic               done_o,
  output logic [WordW-1:0]   cipher_left_o,
  output logic [WordW-1:0]   cipher_right_o,
  input  logic               cfg_we_i,
  input  logic [KeyIdxW-1:0] cfg_idx_i,
  input  logic [WordW-1:0]   cfg_wdata_i
);

  localparam int unsigned NumStages = 2 * ROUND_COUNT;

  logic [WordW-1:0] key0_q, key1_q, key2_q, key3_q;

  logic             valid_q [NumStages];
  logic [WordW-1:0] left_q  [NumStages];
  logic [WordW-1:0] right_q [NumStages];

  // Key register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q <= KeyRst0;
      key1_q <= KeyRst1;
      key2_q <= KeyRst2;
      key3_q <= KeyRst3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        KeyIdx0: key0_q <= cfg_wdata_i;
        KeyIdx1: key1_q <= cfg_wdata_i;
        KeyIdx2: key2_q <= cfg_wdata_i;
        KeyIdx3: key3_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // No back-pressure anywhere in the pipeline.
  assign busy_o = 1'b0;

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    // Running sum of the round this stage belongs to, fixed at elaboration.
    localparam logic [WordW-1:0] RoundSum = TeaDelta * WordW'(s / 2 + 1);

    logic             valid_in;
    logic [WordW-1:0] left_in;
    logic [WordW-1:0] right_in;
    logic [WordW-1:0] left_d;
    logic [WordW-1:0] right_d;

    // Stage input: ports for the first stage, previous stage otherwise.
    if (s == 0) begin : g_first
      assign valid_in = start_i && !busy_o;
      assign left_in  = plain_left_i;
      assign right_in = plain_right_i;
    end else begin : g_next
      assign valid_in = valid_q[s-1];
      assign left_in  = left_q[s-1];
      assign right_in = right_q[s-1];
    end

    // Even stages update the left word, odd stages the right word.
    if (s % 2 == 0) begin : g_left_half
      always_comb begin
        left_d  = left_in + tea_mix(right_in, RoundSum, key0_q, key1_q);
        right_d = right_in;
      end
    end else begin : g_right_half
      always_comb begin
        left_d  = left_in;
        right_d = right_in + tea_mix(left_in, RoundSum, key2_q, key3_q);
      end
    end

    // Valid bit of the stage.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= valid_in;
      end
    end

    // Data words of the stage; loaded only when a beat is present.
    always_ff @(posedge clk_i) begin
      if (valid_in) begin
        left_q[s]  <= left_d;
        right_q[s] <= right_d;
      end
    end
  end

  assign done_o         = valid_q[NumStages-1];
  assign cipher_left_o  = left_q[NumStages-1];
  assign cipher_right_o = right_q[NumStages-1];

endmodule

// File: hdl/tea_chk.sv
module tea_chk
  import tea_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = DefRoundCount
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);

  localparam int unsigned Latency = 2 * ROUND_COUNT;
  localparam int unsigned CntW    = $clog2(Latency + 1);

  logic [CntW-1:0] warm_q;
  logic            warm;

  // Edges seen since reset release, saturating at the pipeline latency.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q <= '0;
    end else if (warm_q != CntW'(Latency)) begin
      warm_q <= warm_q + 1'b1;
    end
  end

  assign warm = (warm_q == CntW'(Latency));

  // Once warm, every result beat traces back to a matching block taken at the input.
  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && done_o) |-> $past(start_i && !busy_o, Latency))
    else $error("result beat without a matching input beat");

  // Once warm, every block taken comes out of the pipeline as a result beat.
  a_source_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && $past(start_i && !busy_o, Latency)) |-> done_o)
    else $error("input beat lost in the pipeline");

  // Once an edge has seen reset low, no result beat shows at the next edge.
  // The stage valid bits are known only after reset has acted on them.
  a_quiet_in_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !done_o)
    else $error("result beat during reset");

endmodule

bind tea_block_encrypt_top tea_chk #(
  .ROUND_COUNT(ROUND_COUNT)
) u_tea_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start_i(start_i),
  .busy_o (busy_o),
  .done_o (done_o)
);
